### rtl/core/mkte_pkg.sv
// shared key codes, event codes, character constants and keypad tables
package mkte_pkg;

    localparam logic [3:0] KEY_SPACE     = 4'd1;
    localparam logic [3:0] KEY_LETTER_LO = 4'd2;
    localparam logic [3:0] KEY_LETTER_HI = 4'd9;
    localparam logic [3:0] KEY_DEL       = 4'd10;
    localparam logic [3:0] KEY_CASE      = 4'd11;
    localparam logic [3:0] KEY_OK        = 4'd12;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_PENDING   = 3'd1;
    localparam logic [2:0] EV_APPENDED  = 3'd2;
    localparam logic [2:0] EV_DELETED   = 3'd3;
    localparam logic [2:0] EV_COMMITTED = 3'd4;
    localparam logic [2:0] EV_EXIT      = 3'd5;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

    // number of letter keys and width of a tap counter
    localparam int          LETTER_KEYS = 8;
    localparam int          TAP_W       = 2;

    typedef struct packed {
        logic step;   // advance the tap counter of the current key
        logic clear;  // clear every tap counter
    } keymap_ctrl_t;

    // offset of a letter key's first letter from 'a'
    function automatic logic [7:0] key_offset(input logic [3:0] key);
        logic [7:0] off;
        begin
            case (key)
                4'd2:    off = 8'd0;
                4'd3:    off = 8'd3;
                4'd4:    off = 8'd6;
                4'd5:    off = 8'd9;
                4'd6:    off = 8'd12;
                4'd7:    off = 8'd15;
                4'd8:    off = 8'd19;
                4'd9:    off = 8'd22;
                default: off = 8'd0;
            endcase
            return off;
        end
    endfunction

    // keys that carry four letters (pqrs, wxyz)
    function automatic logic key_has_four(input logic [3:0] key);
        return (key == 4'd7) || (key == 4'd9);
    endfunction

endpackage

### rtl/core/multitap_keypad_text_entry_top.sv
// multi-tap keypad text entry: control sequencer around the text store
//
// channels: key_code arrives on in_valid/in_ready, one result per request
// leaves on out_valid/out_ready (event_code, pending_char, text_length,
// upper_case_on). target_slot is written on cfg_valid/cfg_ready, which is
// always ready; values at or above SLOT_COUNT edit the last slot.
//
// each request walks the edited slot one byte per cycle through the text
// store's read port to find the text length, then applies the key with at
// most one write back, which waits while the output register is full.
// in_ready is high only between requests.
//
// after reset the store is swept to zero, every byte of every slot, with
// in_ready low; configuration writes are taken. a result waits in the
// output register while out_ready is low; the next request can be
// accepted and scanned, and its update is held until the output register
// frees up.
module multitap_keypad_text_entry_top #(
    parameter int TEXT_LEN   = 10,
    parameter int SLOT_COUNT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] target_slot,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] key_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_code,
    output logic [7:0] pending_char,
    output logic [3:0] text_length,
    output logic       upper_case_on
);

    localparam int DEPTH  = SLOT_COUNT * TEXT_LEN;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POS_W  = $clog2(TEXT_LEN + 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_ACT   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0]          slot_cfg_reg;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [3:0]          key_reg, key_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [POS_W-1:0]    chk_pos_reg, chk_pos_next;
    logic [POS_W-1:0]    len_reg, len_next;
    logic [7:0]          pend_reg, pend_next;
    logic                cap_reg, cap_next;
    logic                armed_reg, armed_next;
    logic                out_valid_reg, out_valid_next;
    logic [2:0]          ev_reg, ev_next;
    logic [3:0]          olen_reg, olen_next;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [7:0]          mem_wr_data;
    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [7:0]          mem_rd_data;

    logic [SLOT_W-1:0]   slot_sel;
    logic [ADDR_W-1:0]   slot_base;
    logic [POS_W-1:0]    new_len;
    logic [POS_W-1:0]    chk_pos_inc;
    logic                is_letter;
    logic                out_free;
    logic [7:0]          letter;
    mkte_pkg::keymap_ctrl_t km_ctrl;

    assign slot_sel  = (32'(slot_cfg_reg) >= SLOT_COUNT) ? SLOT_W'(SLOT_COUNT - 1)
                                                        : SLOT_W'(slot_cfg_reg);
    assign slot_base = ADDR_W'(32'(slot_sel) * TEXT_LEN);
    assign chk_pos_inc = chk_pos_reg + POS_W'(1);
    assign is_letter = (key_reg >= mkte_pkg::KEY_LETTER_LO)
                    && (key_reg <= mkte_pkg::KEY_LETTER_HI);
    assign out_free  = !out_valid_reg || out_ready;

    mkte_text_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_text_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mkte_keymap u_keymap (
        .clk     (clk),
        .rst_n   (rst_n),
        .key     (key_reg),
        .capital (cap_reg),
        .ctrl    (km_ctrl),
        .letter  (letter)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        key_next       = key_reg;
        base_next      = base_reg;
        chk_pos_next   = chk_pos_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        cap_next       = cap_reg;
        armed_next     = armed_reg;
        ev_next        = ev_reg;
        olen_next      = olen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        new_len        = len_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = clr_addr_reg;
        mem_wr_data    = 8'd0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = slot_base;
        km_ctrl        = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next     = key_code;
                    base_next    = slot_base;
                    chk_pos_next = '0;
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = slot_base;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read data is for chk_pos; the next read is issued if the scan goes on
                if (mem_rd_data == 8'd0)
                begin
                    len_next   = chk_pos_reg;
                    state_next = S_ACT;
                end
                else if (chk_pos_reg == POS_W'(TEXT_LEN - 1))
                begin
                    len_next   = POS_W'(TEXT_LEN);
                    state_next = S_ACT;
                end
                else
                begin
                    chk_pos_next = chk_pos_inc;
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = base_reg + ADDR_W'(chk_pos_inc);
                end
            end
            S_ACT:
            begin
                if (out_free)
                begin
                    ev_next = mkte_pkg::EV_NONE;
                    if (key_reg == mkte_pkg::KEY_SPACE)
                    begin
                        pend_next  = mkte_pkg::CHAR_SPACE;
                        armed_next = 1'b0;
                        ev_next    = mkte_pkg::EV_PENDING;
                    end
                    else if (is_letter)
                    begin
                        pend_next    = letter;
                        km_ctrl.step = 1'b1;
                        armed_next   = 1'b0;
                        ev_next      = mkte_pkg::EV_PENDING;
                    end
                    else if (key_reg == mkte_pkg::KEY_CASE)
                    begin
                        cap_next = !cap_reg;
                    end
                    else if (key_reg == mkte_pkg::KEY_DEL)
                    begin
                        if (len_reg == '0)
                        begin
                            ev_next = mkte_pkg::EV_EXIT;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = base_reg + ADDR_W'(len_reg) - ADDR_W'(1);
                            mem_wr_data = 8'd0;
                            new_len     = len_reg - POS_W'(1);
                            ev_next     = mkte_pkg::EV_DELETED;
                        end
                    end
                    else if (key_reg == mkte_pkg::KEY_OK)
                    begin
                        if (armed_reg)
                        begin
                            armed_next = 1'b0;
                            ev_next    = mkte_pkg::EV_COMMITTED;
                        end
                        else
                        begin
                            // a full text takes nothing; a zero byte leaves the length as is
                            if (len_reg < POS_W'(TEXT_LEN))
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = base_reg + ADDR_W'(len_reg);
                                mem_wr_data = pend_reg;
                                if (pend_reg != 8'd0)
                                begin
                                    new_len = len_reg + POS_W'(1);
                                end
                            end
                            km_ctrl.clear = 1'b1;
                            armed_next    = 1'b1;
                            ev_next       = mkte_pkg::EV_APPENDED;
                        end
                    end
                    olen_next      = (32'(new_len) > 15) ? 4'd15 : 4'(new_len);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            slot_cfg_reg  <= 4'd0;
            pend_reg      <= 8'd0;
            cap_reg       <= 1'b0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            cap_reg       <= cap_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                slot_cfg_reg <= target_slot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        base_reg    <= base_next;
        chk_pos_reg <= chk_pos_next;
        len_reg     <= len_next;
        ev_reg      <= ev_next;
        olen_reg    <= olen_next;
    end

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign event_code    = ev_reg;
    assign pending_char  = pend_reg;
    assign text_length   = olen_reg;
    assign upper_case_on = cap_reg;

endmodule

### rtl/core/mkte_text_mem.sv
// single-port-write, single-port-read text store with registered read data
module mkte_text_mem #(
    parameter int DEPTH  = 160,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/mkte_keymap.sv
// per-key tap counters and letter selection for keys 2 to 9
module mkte_keymap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           key,
    input  logic                 capital,
    input  mkte_pkg::keymap_ctrl_t ctrl,
    output logic [7:0]           letter
);

    logic [mkte_pkg::TAP_W-1:0] tap_reg  [mkte_pkg::LETTER_KEYS];
    logic [mkte_pkg::TAP_W-1:0] tap_next [mkte_pkg::LETTER_KEYS];
    logic [2:0]                 idx;
    logic [3:0]                 key_rel;
    logic                       four;
    logic [mkte_pkg::TAP_W-1:0] cnt;
    logic [mkte_pkg::TAP_W-1:0] cnt_mod;
    logic [mkte_pkg::TAP_W-1:0] cnt_inc;
    logic [7:0]                 first;

    assign key_rel = key - mkte_pkg::KEY_LETTER_LO;
    assign idx     = key_rel[2:0];
    assign four    = mkte_pkg::key_has_four(key);
    assign cnt     = tap_reg[idx];

    // a three-letter key folds a stray count of three back to zero
    assign cnt_mod = (!four && cnt == 2'd3) ? 2'd0 : cnt;
    assign cnt_inc = (!four && cnt_mod == 2'd2) ? 2'd0 : cnt_mod + 2'd1;

    assign first  = capital ? mkte_pkg::CHAR_UPPER_A : mkte_pkg::CHAR_LOWER_A;
    assign letter = first + mkte_pkg::key_offset(key) + 8'(cnt_mod);

    always_comb
    begin
        for (int i = 0; i < mkte_pkg::LETTER_KEYS; i++)
        begin
            tap_next[i] = tap_reg[i];
        end
        if (ctrl.clear)
        begin
            for (int i = 0; i < mkte_pkg::LETTER_KEYS; i++)
            begin
                tap_next[i] = '0;
            end
        end
        else if (ctrl.step)
        begin
            tap_next[idx] = cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mkte_pkg::LETTER_KEYS; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < mkte_pkg::LETTER_KEYS; i++)
            begin
                tap_reg[i] <= tap_next[i];
            end
        end
    end

endmodule

### rtl/core/mkte_checker.sv
// port-level checks for the keypad text entry block, bound to the top level
module mkte_checker #(
    parameter int TEXT_LEN = 10
) (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_code,
    input logic [7:0] pending_char,
    input logic [3:0] text_length,
    input logic       upper_case_on
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code)
            && $stable(pending_char) && $stable(text_length) && $stable(upper_case_on))
        else $error("result changed while stalled");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_code <= mkte_pkg::EV_EXIT)
        else $error("event code out of range");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(text_length) <= TEXT_LEN)
        else $error("text length above slot size");

    a_exit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == mkte_pkg::EV_EXIT |-> text_length == 4'd0)
        else $error("exit reported on a non-empty text");

    // a fresh pending character is a space or a letter
    a_pending_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == mkte_pkg::EV_PENDING |->
            pending_char == mkte_pkg::CHAR_SPACE
            || (pending_char >= mkte_pkg::CHAR_LOWER_A && pending_char <= mkte_pkg::CHAR_LOWER_Z)
            || (pending_char >= mkte_pkg::CHAR_UPPER_A && pending_char <= mkte_pkg::CHAR_UPPER_Z))
        else $error("pending character is not a space or letter");

endmodule

bind multitap_keypad_text_entry_top mkte_checker #(
    .TEXT_LEN (TEXT_LEN)
) u_mkte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_code    (event_code),
    .pending_char  (pending_char),
    .text_length   (text_length),
    .upper_case_on (upper_case_on)
);

### test/mkte_entry_checker.sv
// keypad text entry checker: tracks slot, case, taps and texts, compares every result
module mkte_entry_checker
    import mkte_pkg::*;
#(
    parameter int TEXT_LEN   = 10,
    parameter int SLOT_COUNT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [3:0] target_slot,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [3:0] key_code,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] event_code,
    input  logic [7:0] pending_char,
    input  logic [3:0] text_length,
    input  logic       upper_case_on,
    output int         fail_count,
    output int         outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] ch;
        logic [3:0] len;
        logic       caps;
    } entry_result_t;

    logic [3:0]    slot_sel;
    logic [7:0]    chosen_char;
    logic          caps_on;
    logic          ok_armed;
    logic [1:0]    tap_cnt [10];
    logic [7:0]    slot_text [SLOT_COUNT][TEXT_LEN];
    entry_result_t expected_entry_q [$];
    entry_result_t want;

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("%0t: mismatch on %s: got %0d, wanted %0d", $realtime, what, got, wanted);
        fail_count++;
    endtask

    function automatic int text_len(input int s);
        int n;
        n = 0;
        while (n < TEXT_LEN && slot_text[s][n] != 8'd0)
            n++;
        return n;
    endfunction

    function automatic entry_result_t apply_keypress(input logic [3:0] key);
        entry_result_t r;
        int            s;
        int            n;
        int            span;
        int            base;
        int            c;
        s = (int'(slot_sel) >= SLOT_COUNT) ? SLOT_COUNT - 1 : int'(slot_sel);
        n = text_len(s);
        r.ev = EV_NONE;
        if (key == KEY_SPACE)
        begin
            chosen_char = CHAR_SPACE;
            ok_armed = 1'b0;
            r.ev = EV_PENDING;
        end
        else if (key >= KEY_LETTER_LO && key <= KEY_LETTER_HI)
        begin
            // pqrs and wxyz carry four letters, the rest three
            span = (key == 4'd7 || key == 4'd9) ? 4 : 3;
            base = 3 * (int'(key) - 2) + ((key > 4'd7) ? 1 : 0);
            c = int'(tap_cnt[key]) % span;
            chosen_char = (caps_on ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(base + c);
            tap_cnt[key] = 2'((c + 1) % span);
            ok_armed = 1'b0;
            r.ev = EV_PENDING;
        end
        else if (key == KEY_CASE)
        begin
            caps_on = ~caps_on;
        end
        else if (key == KEY_DEL)
        begin
            if (n == 0)
            begin
                r.ev = EV_EXIT;
            end
            else
            begin
                slot_text[s][n - 1] = 8'd0;
                r.ev = EV_DELETED;
            end
        end
        else if (key == KEY_OK)
        begin
            if (ok_armed)
            begin
                ok_armed = 1'b0;
                r.ev = EV_COMMITTED;
            end
            else
            begin
                // a zero pending byte just terminates the text again
                if (n < TEXT_LEN)
                    slot_text[s][n] = chosen_char;
                for (int i = 0; i < 10; i++)
                    tap_cnt[i] = 2'd0;
                ok_armed = 1'b1;
                r.ev = EV_APPENDED;
            end
        end
        n = text_len(s);
        r.len = (n > 15) ? 4'd15 : 4'(n);
        r.ch = chosen_char;
        r.caps = caps_on;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_sel = 4'd0;
            chosen_char = 8'd0;
            caps_on = 1'b0;
            ok_armed = 1'b0;
            for (int i = 0; i < 10; i++)
                tap_cnt[i] = 2'd0;
            for (int s = 0; s < SLOT_COUNT; s++)
                for (int j = 0; j < TEXT_LEN; j++)
                    slot_text[s][j] = 8'd0;
            expected_entry_q.delete();
        end
        else
        begin
            // results first: the block never answers a request in its accept cycle
            if (out_valid && out_ready)
            begin
                if (expected_entry_q.size() == 0)
                begin
                    report_mismatch("result with none expected", event_code, EV_NONE);
                end
                else
                begin
                    want = expected_entry_q.pop_front();
                    if (event_code !== want.ev)
                        report_mismatch("event_code", event_code, want.ev);
                    if (pending_char !== want.ch)
                        report_mismatch("pending_char", pending_char, want.ch);
                    if (text_length !== want.len)
                        report_mismatch("text_length", text_length, want.len);
                    if (upper_case_on !== want.caps)
                        report_mismatch("upper_case_on", upper_case_on, want.caps);
                end
            end
            if (cfg_valid && cfg_ready)
                slot_sel = target_slot;
            if (in_valid && in_ready)
                expected_entry_q.push_back(apply_keypress(key_code));
        end
        outstanding = expected_entry_q.size();
    end

endmodule

### test/tb_multitap_keypad_text_entry_top.sv
// testbench top for the multi-tap keypad text entry block: stimulus and verdict
module tb_multitap_keypad_text_entry_top;

    import mkte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_LEN      = 10;
    localparam int SLOT_COUNT    = 16;
    localparam int SETTLE_CYCLES = 3 * (TEXT_LEN + 2);
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 194;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [3:0] KEY_UNUSED_0  = 4'd0;
    localparam logic [3:0] KEY_UNUSED_13 = 4'd13;
    localparam logic [3:0] KEY_UNUSED_14 = 4'd14;
    localparam logic [3:0] KEY_UNUSED_15 = 4'd15;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] target_slot;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] key_code;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] event_code;
    logic [7:0] pending_char;
    logic [3:0] text_length;
    logic       upper_case_on;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int keys_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    logic hold_taken = 1'b0;

    multitap_keypad_text_entry_top #(
        .TEXT_LEN   (TEXT_LEN),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .target_slot   (target_slot),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_code      (key_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_code    (event_code),
        .pending_char  (pending_char),
        .text_length   (text_length),
        .upper_case_on (upper_case_on)
    );

    mkte_entry_checker #(
        .TEXT_LEN   (TEXT_LEN),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .target_slot   (target_slot),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_code      (key_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_code    (event_code),
        .pending_char  (pending_char),
        .text_length   (text_length),
        .upper_case_on (upper_case_on),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off once it is requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0 && !hold_taken)
            begin
                hold_left = hold_req;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_key(input logic [3:0] k);
        in_valid <= 1'b1;
        key_code <= k;
        do @(posedge clk); while (!in_ready);
        if (k >= KEY_SPACE && k <= KEY_OK)
            keys_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // hold requests back until every result is in
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_slot(input logic [3:0] slot);
        cfg_valid <= 1'b1;
        target_slot <= slot;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // tap out a word, confirm it, maybe commit, maybe back it out again
    task automatic type_word();
        int         n;
        logic [3:0] k;
        n = $urandom_range(1, 12);
        repeat (n)
        begin
            if ($urandom_range(9) == 0)
                send_key(KEY_CASE);
            if ($urandom_range(9) == 0)
            begin
                send_key(KEY_SPACE);
            end
            else
            begin
                k = 4'($urandom_range(KEY_LETTER_HI, KEY_LETTER_LO));
                repeat ($urandom_range(1, 5))
                    send_key(k);
            end
            send_key(KEY_OK);
        end
        if ($urandom_range(1) == 0)
            send_key(KEY_OK);
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(1, 12))
                send_key(KEY_DEL);
    endtask

    initial
    begin
        int         iter;
        int         goal;
        int         idx;
        logic [3:0] slot;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        target_slot = 4'd0;
        in_valid = 1'b0;
        key_code = KEY_UNUSED_0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_slot(4'd0);

        send_key(KEY_UNUSED_0);
        send_key(KEY_UNUSED_13);
        send_key(KEY_UNUSED_14);
        send_key(KEY_UNUSED_15);
        send_key(KEY_DEL);          // exit on empty text
        send_key(KEY_OK);           // nothing pending yet
        send_key(KEY_OK);           // commit
        send_key(KEY_LETTER_LO);
        send_key(KEY_LETTER_LO);
        send_key(4'd7);             // pqrs
        send_key(KEY_CASE);         // pending stays lower case
        send_key(4'd7);             // counter kept across key changes
        send_key(KEY_LETTER_HI);
        send_key(KEY_OK);
        send_key(KEY_DEL);
        send_key(KEY_DEL);
        send_key(KEY_SPACE);
        send_key(KEY_OK);
        send_key(KEY_OK);
        send_key(4'd8);             // tuv, wraps on the fourth tap
        send_key(4'd8);
        send_key(4'd8);
        send_key(4'd8);
        send_key(KEY_CASE);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 48;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 48;
                end
                default:
                begin
                    idle_pct = 31;
                    stall_pct = 31;
                end
            endcase
            for (int sub = 0; sub < 2; sub++)
            begin
                idx = 2 * ph + sub;
                if (idx == 0 || idx == 4)
                    slot = 4'd0;
                else if (idx == 1 || idx == 6)
                    slot = 4'd15;
                else
                    slot = 4'($urandom_range(1, 14));
                write_slot(slot);
                if (idx == 1)
                    hold_req = HOLD_CYCLES;
                goal = keys_sent + PHASE_ITEMS;
                iter = 0;
                while (keys_sent < goal)
                begin
                    if (iter == 8)
                        drain();
                    if ($urandom_range(3) == 0)
                    begin
                        repeat ($urandom_range(1, 6))
                            send_key(4'($urandom_range(15)));
                    end
                    else
                    begin
                        type_word();
                    end
                    iter++;
                end
                drain();
            end
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
